[hw/rtl/tsmu_pkg.sv]
// shared constants, types and exp tables of the trotter slice metropolis update block
`default_nettype none

package tsmu_pkg;

   localparam int SLICES    = 1024;
   localparam int SPINS     = 128;
   localparam int FRAC_BITS = 16;

   localparam int SLICE_AW  = $clog2(SLICES);
   localparam int SPIN_AW   = $clog2(SPINS);
   localparam int WT_W      = $clog2(SPINS + 1);
   localparam int LAT_W     = $clog2(SLICES * SPINS + 1);

   localparam int TERM_W    = 18;
   localparam int PROD_W    = TERM_W + 25;
   localparam int NB_W      = 28;
   localparam int COST_W    = PROD_W + 1;
   localparam int D_W       = FRAC_BITS - 4;
   localparam int E_W       = FRAC_BITS + 1;
   localparam int EXP_INT_LAST = 20;

   localparam logic [1:0] CSR_SLICE_SCALE  = 2'd0;
   localparam logic [1:0] CSR_COUPLING     = 2'd1;
   localparam logic [1:0] CSR_SPIKE_HEIGHT = 2'd2;
   localparam logic [1:0] CSR_SPIKE_WEIGHT = 2'd3;

   localparam logic       OP_LOAD    = 1'b0;
   localparam logic       OP_ATTEMPT = 1'b1;

   typedef struct packed {
      logic                rd_a;
      logic [SLICE_AW-1:0] addr_a;
      logic                rd_b;
      logic [SLICE_AW-1:0] addr_b;
      logic                wr;
      logic [SLICE_AW-1:0] wr_addr;
      logic [SPINS-1:0]    wr_row;
      logic [WT_W-1:0]     wr_wt;
   } store_req_type;

   typedef struct packed {
      logic [SPINS-1:0] row_a;
      logic [SPINS-1:0] row_b;
      logic [WT_W-1:0]  wt_a;
      logic             busy;
   } store_rsp_type;

   function automatic logic [30:0] exp_int_q30(input logic [4:0] idx);
      logic [30:0] v;
      case (idx)
         5'd0:    v = 31'd1073741824;
         5'd1:    v = 31'd395007542;
         5'd2:    v = 31'd145315153;
         5'd3:    v = 31'd53458457;
         5'd4:    v = 31'd19666267;
         5'd5:    v = 31'd7234815;
         5'd6:    v = 31'd2661539;
         5'd7:    v = 31'd979125;
         5'd8:    v = 31'd360200;
         5'd9:    v = 31'd132509;
         5'd10:   v = 31'd48747;
         5'd11:   v = 31'd17933;
         5'd12:   v = 31'd6597;
         5'd13:   v = 31'd2427;
         5'd14:   v = 31'd892;
         5'd15:   v = 31'd328;
         5'd16:   v = 31'd120;
         5'd17:   v = 31'd44;
         5'd18:   v = 31'd16;
         5'd19:   v = 31'd6;
         5'd20:   v = 31'd2;
         default: v = 31'd0;
      endcase
      return v;
   endfunction

   function automatic logic [30:0] exp_frac_q30(input logic [3:0] idx);
      logic [30:0] v;
      case (idx)
         4'd0:    v = 31'd1073741824;
         4'd1:    v = 31'd1008687095;
         4'd2:    v = 31'd947573833;
         4'd3:    v = 31'd890163237;
         4'd4:    v = 31'd836230973;
         4'd5:    v = 31'd785566299;
         4'd6:    v = 31'd737971243;
         4'd7:    v = 31'd693259824;
         4'd8:    v = 31'd651257336;
         4'd9:    v = 31'd611799649;
         4'd10:   v = 31'd574732582;
         4'd11:   v = 31'd539911295;
         4'd12:   v = 31'd507199723;
         4'd13:   v = 31'd476470046;
         4'd14:   v = 31'd447602185;
         default: v = 31'd420483340;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/tsmu_channels.sv]
// request, response and csr channel interfaces
`default_nettype none

interface tsmu_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [9:0]  slice;
   logic [6:0]  spin;
   logic        load_value;
   logic [15:0] random;

   modport source (output valid, operation, slice, spin, load_value, random, input ready);
   modport sink   (input valid, operation, slice, spin, load_value, random, output ready);
endinterface

interface tsmu_rsp_if;
   logic        valid;
   logic        ready;
   logic        accepted;
   logic        spin_now;
   logic [7:0]  slice_weight;
   logic [17:0] total_weight;

   modport source (output valid, accepted, spin_now, slice_weight, total_weight, input ready);
   modport sink   (input valid, accepted, spin_now, slice_weight, total_weight, output ready);
endinterface

interface tsmu_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [23:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/tsmu_store.sv]
// spin row memory and slice weight memory with clearing pass after reset
`default_nettype none

module tsmu_store
   import tsmu_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire store_req_type req,
   output      store_rsp_type rsp
);

   logic [SPINS-1:0]    spin_mem [SLICES];
   logic [WT_W-1:0]     wt_mem   [SLICES];

   logic [SPINS-1:0]    row_a_ff;
   logic [SPINS-1:0]    row_b_ff;
   logic [WT_W-1:0]     wt_a_ff;
   logic                clr_busy_ff, clr_busy_in;
   logic [SLICE_AW-1:0] clr_addr_ff, clr_addr_in;

   logic                wr_en;
   logic [SLICE_AW-1:0] wr_addr;
   logic [SPINS-1:0]    wr_row;
   logic [WT_W-1:0]     wr_wt;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == SLICE_AW'(SLICES - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
      if (clr_busy_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_row  = '0;
         wr_wt   = '0;
      end else begin
         wr_en   = req.wr;
         wr_addr = req.wr_addr;
         wr_row  = req.wr_row;
         wr_wt   = req.wr_wt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         spin_mem[wr_addr] <= wr_row;
         wt_mem[wr_addr]   <= wr_wt;
      end
      if (req.rd_a) begin
         row_a_ff <= spin_mem[req.addr_a];
         wt_a_ff  <= wt_mem[req.addr_a];
      end
      if (req.rd_b) begin
         row_b_ff <= spin_mem[req.addr_b];
      end
   end

   assign rsp.row_a = row_a_ff;
   assign rsp.row_b = row_b_ff;
   assign rsp.wt_a  = wt_a_ff;
   assign rsp.busy  = clr_busy_ff;

endmodule

`default_nettype wire

[hw/rtl/tsmu_exp_unit.sv]
// two-stage exp(-x) evaluation in q30 from table factors and a linear fraction term
`default_nettype none

module tsmu_exp_unit
   import tsmu_pkg::*;
(
   input  wire logic           clock,
   input  wire logic [4:0]     ipart,
   input  wire logic [3:0]     jpart,
   input  wire logic [D_W-1:0] dpart,
   output      logic [E_W-1:0] e_val
);

   logic [30:0]    m1_ff, m1_in;
   logic [D_W-1:0] d1_ff;
   logic [E_W-1:0] e_ff, e_in;
   logic [61:0]    p1;
   logic [61:0]    p2;
   logic [30:0]    lin;
   logic [25:0]    d_sh;

   always_comb begin
      p1    = 62'(exp_int_q30(ipart)) * 62'(exp_frac_q30(jpart));
      m1_in = p1[60:30];
      d_sh  = {d1_ff, {(30 - FRAC_BITS){1'b0}}};
      lin   = 31'h4000_0000 - 31'(d_sh);
      p2    = 62'(m1_ff) * 62'(lin);
      e_in  = p2[60:60-FRAC_BITS];
   end

   always_ff @(posedge clock) begin
      m1_ff <= m1_in;
      d1_ff <= dpart;
      e_ff  <= e_in;
   end

   assign e_val = e_ff;

endmodule

`default_nettype wire

[hw/rtl/trotter_slice_metropolis_update.sv]
// top level: item sequencer, cost datapath, csr file, result register
// sequencing: a request steps through read, term, cost, exp1, exp2 and done; done
//   loads the result register once the last result is taken; no overlap, set by the
//   two-port reads of own and neighbor rows and the two registered exp stages
// reset: csr registers take their reset values, counts clear at once, and a
//   clearing pass zeroes the memories; req ready stays low meanwhile
`default_nettype none

module trotter_slice_metropolis_update
   import tsmu_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   tsmu_req_if.sink   req_ch,
   tsmu_rsp_if.source rsp_ch,
   tsmu_csr_if.sink   csr_ch
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_TERM = 3'd2;
   localparam logic [2:0] ST_COST = 3'd3;
   localparam logic [2:0] ST_EXP1 = 3'd4;
   localparam logic [2:0] ST_EXP2 = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   store_req_type sreq;
   store_rsp_type srsp;

   logic [2:0]  state_ff, state_in;

   logic [23:0] slice_scale_ff, coupling_ff;
   logic [15:0] spike_height_ff;
   logic [7:0]  spike_weight_ff;

   logic                op_ff, lv_ff, range_ff;
   logic [SLICE_AW-1:0] slice_ff, above_ff;
   logic [SPIN_AW-1:0]  spin_ff;
   logic [15:0]         rnd_ff;
   logic                cur_ff, below_ff;
   logic [WT_W-1:0]     wt_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [NB_W-1:0]   nb_ff;
   logic                neg_ff;
   logic [4:0]          ip_ff;
   logic [3:0]          j_ff;
   logic [D_W-1:0]      d_ff;
   logic [LAT_W-1:0]    lattice_ff, lattice_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                acc_ff, acc_in;
   logic                spin_now_ff, spin_now_in;
   logic [7:0]          sw_ff, sw_in;
   logic [17:0]         tw_ff, tw_in;

   logic [E_W-1:0]      e_val;

   logic                req_xfer, csr_xfer, out_free, in_range;
   logic [SLICE_AW-1:0] sl, below_addr, above_addr;
   logic                flip_bit, above_bit;
   logic [15:0]         wn;
   logic signed [TERM_W-1:0] term;
   logic signed [PROD_W-1:0] prod;
   logic signed [NB_W-1:0]   jj, nb;
   logic signed [COST_W-1:0] cost;
   logic [16:0]         rnd_p1;
   logic [E_W+15:0]     e_cmp, r_cmp;
   logic                acc, new_bit, changed;
   logic [WT_W-1:0]     wt_new;
   logic [SPINS-1:0]    row_new;

   tsmu_store u_store (
      .clock (clock),
      .reset (reset),
      .req   (sreq),
      .rsp   (srsp)
   );

   tsmu_exp_unit u_exp (
      .clock (clock),
      .ipart (ip_ff),
      .jpart (j_ff),
      .dpart (d_ff),
      .e_val (e_val)
   );

   assign req_ch.ready = (state_ff == ST_IDLE) && !srsp.busy;
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign csr_xfer     = csr_ch.valid;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   // address decode for the accepted item
   always_comb begin
      sl         = SLICE_AW'(req_ch.slice);
      in_range   = (32'(req_ch.slice) < SLICES) && (32'(req_ch.spin) < SPINS);
      below_addr = (sl == '0) ? SLICE_AW'(SLICES - 1) : sl - 1'b1;
      above_addr = (sl == SLICE_AW'(SLICES - 1)) ? '0 : sl + 1'b1;
   end

   // cost datapath
   always_comb begin
      flip_bit  = ~cur_ff;
      above_bit = srsp.row_b[spin_ff];
      wn        = flip_bit ? 16'(wt_ff) + 16'd1 : 16'(wt_ff) - 16'd1;
      if (wn == 16'(spike_weight_ff)) begin
         term = $signed({2'b00, spike_height_ff} - TERM_W'(wt_ff));
      end else begin
         term = flip_bit ? TERM_W'(1) : -TERM_W'(1);
      end
      prod = term * $signed({1'b0, slice_scale_ff});
      jj   = $signed({3'b000, coupling_ff, 1'b0});
      nb   = ((below_ff == flip_bit) ? -jj : jj) + ((above_bit == flip_bit) ? -jj : jj);
      cost = COST_W'(prod_ff) + COST_W'(nb_ff);
   end

   // decision and write-back
   always_comb begin
      rnd_p1 = {1'b0, rnd_ff} + 17'd1;
      e_cmp  = {e_val, 16'b0};
      r_cmp  = {rnd_p1, {FRAC_BITS{1'b0}}};
      if (!range_ff) begin
         acc = 1'b0;
      end else if (op_ff == OP_LOAD) begin
         acc = 1'b1;
      end else begin
         acc = neg_ff || (e_cmp > r_cmp);
      end
      if (op_ff == OP_LOAD) begin
         new_bit = lv_ff;
      end else begin
         new_bit = acc ? ~cur_ff : cur_ff;
      end
      changed = range_ff && (new_bit != cur_ff);
      if (changed) begin
         wt_new = new_bit ? wt_ff + 1'b1 : wt_ff - 1'b1;
      end else begin
         wt_new = wt_ff;
      end
      row_new          = srsp.row_a;
      row_new[spin_ff] = new_bit;
   end

   // sequencer and store requests
   always_comb begin
      state_in     = state_ff;
      lattice_in   = lattice_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      acc_in       = acc_ff;
      spin_now_in  = spin_now_ff;
      sw_in        = sw_ff;
      tw_in        = tw_ff;
      sreq         = '0;
      sreq.addr_a  = sl;
      sreq.addr_b  = below_addr;
      sreq.wr_addr = slice_ff;
      sreq.wr_row  = row_new;
      sreq.wr_wt   = wt_new;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               sreq.rd_a = 1'b1;
               sreq.rd_b = 1'b1;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            sreq.rd_b   = 1'b1;
            sreq.addr_b = above_ff;
            state_in    = ST_TERM;
         end
         ST_TERM: state_in = ST_COST;
         ST_COST: state_in = ST_EXP1;
         ST_EXP1: state_in = ST_EXP2;
         ST_EXP2: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               sreq.wr = changed;
               if (changed) begin
                  lattice_in = new_bit ? lattice_ff + 1'b1 : lattice_ff - 1'b1;
               end
               rsp_valid_in = 1'b1;
               acc_in       = acc;
               spin_now_in  = range_ff && new_bit;
               sw_in        = range_ff ? 8'(wt_new) : 8'd0;
               tw_in        = changed ? 18'(new_bit ? lattice_ff + 1'b1 : lattice_ff - 1'b1)
                                      : 18'(lattice_ff);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         lattice_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
         slice_scale_ff  <= 24'd2097;
         coupling_ff     <= 24'd112800;
         spike_height_ff <= 16'd128;
         spike_weight_ff <= 8'd32;
      end else begin
         state_ff     <= state_in;
         lattice_ff   <= lattice_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_xfer) begin
            unique case (csr_ch.index)
               CSR_SLICE_SCALE:  slice_scale_ff  <= csr_ch.data;
               CSR_COUPLING:     coupling_ff     <= csr_ch.data;
               CSR_SPIKE_HEIGHT: spike_height_ff <= csr_ch.data[15:0];
               CSR_SPIKE_WEIGHT: spike_weight_ff <= csr_ch.data[7:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      spin_now_ff <= spin_now_in;
      sw_ff       <= sw_in;
      tw_ff       <= tw_in;
      if (req_xfer) begin
         op_ff    <= req_ch.operation;
         lv_ff    <= req_ch.load_value;
         rnd_ff   <= req_ch.random;
         range_ff <= in_range;
         slice_ff <= sl;
         above_ff <= above_addr;
         spin_ff  <= SPIN_AW'(req_ch.spin);
      end
      if (state_ff == ST_READ) begin
         cur_ff   <= srsp.row_a[spin_ff];
         below_ff <= srsp.row_b[spin_ff];
         wt_ff    <= srsp.wt_a;
      end
      if (state_ff == ST_TERM) begin
         prod_ff <= prod;
         nb_ff   <= nb;
      end
      if (state_ff == ST_COST) begin
         neg_ff <= cost[COST_W-1];
         if (cost[COST_W-1:FRAC_BITS] > (COST_W - FRAC_BITS)'(EXP_INT_LAST)) begin
            ip_ff <= 5'(EXP_INT_LAST + 1);
         end else begin
            ip_ff <= cost[FRAC_BITS+4:FRAC_BITS];
         end
         j_ff <= cost[FRAC_BITS-1:FRAC_BITS-4];
         d_ff <= cost[D_W-1:0];
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.accepted     = acc_ff;
   assign rsp_ch.spin_now     = spin_now_ff;
   assign rsp_ch.slice_weight = sw_ff;
   assign rsp_ch.total_weight = tw_ff;

`ifndef ASSERT_OFF
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> ($past(state_ff) == ST_DONE))
      else $error("result valid raised outside the done step");

   a_xfer_starts_read: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == ST_READ))
      else $error("request transfer did not start a read");

   a_done_retires: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free) |=> (state_ff == ST_IDLE && rsp_valid_ff))
      else $error("done step did not deliver a result");

   a_lattice_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (lattice_ff == $past(lattice_ff)
                         || lattice_ff == $past(lattice_ff) + 1'b1
                         || lattice_ff == $past(lattice_ff) - 1'b1))
      else $error("lattice count moved by more than one");
`endif

endmodule

`default_nettype wire
